// ===== rtl/hpfa_pkg.sv =====
`timescale 1ns / 1ps

package hpfa_pkg;

	localparam int REQ_W = 2;
	localparam int HDL_W = 6;
	localparam int STS_W = 2;

	typedef logic [REQ_W-1:0] req_t;
	typedef logic [HDL_W-1:0] handle_t;
	typedef logic [STS_W-1:0] status_t;

	localparam req_t REQ_ALLOC = 2'd0;
	localparam req_t REQ_TRY   = 2'd1;
	localparam req_t REQ_FREE  = 2'd2;

	localparam status_t STS_OK       = 2'd0;
	localparam status_t STS_NONE     = 2'd1;
	localparam status_t STS_BAD_FREE = 2'd2;

endpackage

// ===== rtl/handle_pool_fifo_allocator.sv =====
`timescale 1ns / 1ps
// A request and its mark and release memory reads are registered at its transfer;
// the memories are written back and its result registered when it executes, which
// waits while a held result is stalled. No new request is taken until then.
// Reset (arst_n low) empties the release queue and restarts fresh handles at zero;
// the in-use marks need no clearing pass, as marks at or above next_fresh read as zero.

module handle_pool_fifo_allocator #(
	parameter int POOL_SIZE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  hpfa_pkg::req_t    req_type,
	input  hpfa_pkg::handle_t free_handle,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output hpfa_pkg::handle_t granted_handle,
	output hpfa_pkg::status_t status
);
	import hpfa_pkg::*;

	localparam int HW = $clog2(POOL_SIZE);
	localparam int NW = $clog2(POOL_SIZE + 1);
	localparam int XW = (NW > HDL_W) ? NW : HDL_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;

	logic [HW-1:0] head_q;
	logic [HW-1:0] tail_q;
	logic [NW-1:0] count_q;
	logic [NW-1:0] fresh_q;

	logic          rsp_valid_q;
	handle_t       granted_q;
	status_t       status_q;

	req_t          req_s1;
	logic [HW-1:0] hdl_s1;
	logic          in_range_s1;

	logic          mark_mem [POOL_SIZE];
	logic [HW-1:0] fifo_mem [POOL_SIZE];
	logic          mark_rd_s1;
	logic [HW-1:0] fifo_rd_s1;

	logic          accept;
	logic          exec_fire;
	logic [XW-1:0] free_x;

	logic          mark_we;
	logic [HW-1:0] mark_wa;
	logic          mark_wd;
	logic          push;
	logic          pop;
	logic          take_fresh;
	logic [HW-1:0] grant_h;
	status_t       sts;
	logic          mark_set;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign exec_fire = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign free_x    = XW'(free_handle);

	// A handle at or above next_fresh was never handed out, so its mark is clear
	// whatever the memory holds.
	assign mark_set = (XW'(hdl_s1) < XW'(fresh_q)) && mark_rd_s1;

	always_comb begin
		mark_we    = 1'b0;
		mark_wa    = hdl_s1;
		mark_wd    = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		take_fresh = 1'b0;
		grant_h    = '0;
		sts        = STS_OK;
		case (req_s1)
			REQ_ALLOC: begin
				if (count_q != '0) begin
					pop     = 1'b1;
					grant_h = fifo_rd_s1;
					mark_we = 1'b1;
					mark_wa = fifo_rd_s1;
					mark_wd = 1'b1;
				end else if (fresh_q < NW'(POOL_SIZE)) begin
					take_fresh = 1'b1;
					grant_h    = fresh_q[HW-1:0];
					mark_we    = 1'b1;
					mark_wa    = fresh_q[HW-1:0];
					mark_wd    = 1'b1;
				end else begin
					sts = STS_NONE;
				end
			end
			REQ_TRY: begin
				if (count_q != '0) begin
					pop     = 1'b1;
					grant_h = fifo_rd_s1;
					mark_we = 1'b1;
					mark_wa = fifo_rd_s1;
					mark_wd = 1'b1;
				end else begin
					sts = STS_NONE;
				end
			end
			REQ_FREE: begin
				if (in_range_s1 && mark_set) begin
					mark_we = 1'b1;
					mark_wa = hdl_s1;
					mark_wd = 1'b0;
					push    = (count_q < NW'(POOL_SIZE));
				end else begin
					sts = STS_BAD_FREE;
				end
			end
			default: begin
				sts = STS_OK;
			end
		endcase
	end

	// Memories: read at the request transfer, written back when the request executes.
	// The next read only happens after the write-back, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (exec_fire && mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		if (accept) begin
			mark_rd_s1 <= mark_mem[free_x[HW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire && push) begin
			fifo_mem[tail_q] <= hdl_s1;
		end
		if (accept) begin
			fifo_rd_s1 <= fifo_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req_type;
			hdl_s1      <= free_x[HW-1:0];
			in_range_s1 <= (free_x < XW'(POOL_SIZE));
		end
		if (exec_fire) begin
			granted_q <= HDL_W'(grant_h);
			status_q  <= sts;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (exec_fire) begin
				if (pop) begin
					head_q  <= (head_q == HW'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
				if (push) begin
					tail_q  <= (tail_q == HW'(POOL_SIZE - 1)) ? '0 : tail_q + 1'b1;
					count_q <= count_q + 1'b1;
				end
				if (take_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
			end

			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign granted_handle = granted_q;
	assign status         = status_q;

endmodule

// ===== rtl/hpfa_checker.sv =====
`timescale 1ns / 1ps

module hpfa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input hpfa_pkg::req_t    req_type,
	input hpfa_pkg::handle_t free_handle,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input hpfa_pkg::handle_t granted_handle,
	input hpfa_pkg::status_t status
);
	import hpfa_pkg::*;

	// Only one request is worked on at a time.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another was still in progress");

	// A new result only appears after a request has been worked on.
	a_result_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a request in progress");

	// A refused request hands out no handle.
	a_refusal_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STS_OK |-> granted_handle == '0)
		else $error("handle given with a failing status");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(granted_handle) && $stable(status))
		else $error("stalled result changed");

endmodule

bind handle_pool_fifo_allocator hpfa_checker u_hpfa_checker (.*);
